FILE: rtl/ami_pkg.sv
`default_nettype none

package ami_pkg;

    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int N_ELEMS = 12;
    localparam int PC_W    = 7;

    // scratch memory map: matrix elements at 0..11, inverse at 16..27
    localparam logic [ADDR_W-1:0] A_R    = 5'd12;
    localparam logic [ADDR_W-1:0] A_DET  = 5'd13;
    localparam logic [ADDR_W-1:0] A_T1   = 5'd14;
    localparam logic [ADDR_W-1:0] A_T2   = 5'd15;
    localparam logic [ADDR_W-1:0] A_M    = 5'd16;
    localparam logic [ADDR_W-1:0] A_ONE  = 5'd31;

    // element addresses
    localparam logic [ADDR_W-1:0] S00 = 5'd0;
    localparam logic [ADDR_W-1:0] S01 = 5'd1;
    localparam logic [ADDR_W-1:0] S02 = 5'd2;
    localparam logic [ADDR_W-1:0] S03 = 5'd3;
    localparam logic [ADDR_W-1:0] S10 = 5'd4;
    localparam logic [ADDR_W-1:0] S11 = 5'd5;
    localparam logic [ADDR_W-1:0] S12 = 5'd6;
    localparam logic [ADDR_W-1:0] S13 = 5'd7;
    localparam logic [ADDR_W-1:0] S20 = 5'd8;
    localparam logic [ADDR_W-1:0] S21 = 5'd9;
    localparam logic [ADDR_W-1:0] S22 = 5'd10;
    localparam logic [ADDR_W-1:0] S23 = 5'd11;

    localparam logic [ADDR_W-1:0] M00 = 5'd16;
    localparam logic [ADDR_W-1:0] M01 = 5'd17;
    localparam logic [ADDR_W-1:0] M02 = 5'd18;
    localparam logic [ADDR_W-1:0] M03 = 5'd19;
    localparam logic [ADDR_W-1:0] M10 = 5'd20;
    localparam logic [ADDR_W-1:0] M11 = 5'd21;
    localparam logic [ADDR_W-1:0] M12 = 5'd22;
    localparam logic [ADDR_W-1:0] M13 = 5'd23;
    localparam logic [ADDR_W-1:0] M20 = 5'd24;
    localparam logic [ADDR_W-1:0] M21 = 5'd25;
    localparam logic [ADDR_W-1:0] M22 = 5'd26;
    localparam logic [ADDR_W-1:0] M23 = 5'd27;

    localparam logic [WORD_W-1:0] F_ONE    = 32'h3F80_0000;
    localparam logic [WORD_W-1:0] F_DEFNAN = 32'hFFC0_0000;
    localparam logic [WORD_W-1:0] F_QBIT   = 32'h0040_0000;

    localparam logic [PC_W-1:0] PC_DET  = 7'd16;
    localparam logic [PC_W-1:0] PC_LAST = 7'd68;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] d;
        logic              neg;
    } uop_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } fpu_rsp_t;

    function automatic uop_t mk(op_t op, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                                logic [ADDR_W-1:0] d, logic neg);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.d   = d;
        u.neg = neg;
        return u;
    endfunction

    // microprogram: determinant, reciprocal, cofactors, translation column
    function automatic uop_t ucode(logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            7'd0:  u = mk(OP_MUL, S00, S11, A_T1, 1'b0);
            7'd1:  u = mk(OP_MUL, A_T1, S22, A_DET, 1'b0);
            7'd2:  u = mk(OP_MUL, S01, S12, A_T1, 1'b0);
            7'd3:  u = mk(OP_MUL, A_T1, S20, A_T1, 1'b0);
            7'd4:  u = mk(OP_ADD, A_DET, A_T1, A_DET, 1'b0);
            7'd5:  u = mk(OP_MUL, S02, S10, A_T1, 1'b0);
            7'd6:  u = mk(OP_MUL, A_T1, S21, A_T1, 1'b0);
            7'd7:  u = mk(OP_ADD, A_DET, A_T1, A_DET, 1'b0);
            7'd8:  u = mk(OP_MUL, S20, S11, A_T1, 1'b0);
            7'd9:  u = mk(OP_MUL, A_T1, S02, A_T1, 1'b0);
            7'd10: u = mk(OP_SUB, A_DET, A_T1, A_DET, 1'b0);
            7'd11: u = mk(OP_MUL, S10, S01, A_T1, 1'b0);
            7'd12: u = mk(OP_MUL, A_T1, S22, A_T1, 1'b0);
            7'd13: u = mk(OP_SUB, A_DET, A_T1, A_DET, 1'b0);
            7'd14: u = mk(OP_MUL, S00, S21, A_T1, 1'b0);
            7'd15: u = mk(OP_MUL, A_T1, S12, A_T1, 1'b0);
            7'd16: u = mk(OP_SUB, A_DET, A_T1, A_DET, 1'b0);
            7'd17: u = mk(OP_DIV, A_ONE, A_DET, A_R, 1'b0);
            // m00
            7'd18: u = mk(OP_MUL, S11, S22, A_T1, 1'b0);
            7'd19: u = mk(OP_MUL, S21, S12, A_T2, 1'b0);
            7'd20: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd21: u = mk(OP_MUL, A_T1, A_R, M00, 1'b0);
            // m01
            7'd22: u = mk(OP_MUL, S01, S22, A_T1, 1'b0);
            7'd23: u = mk(OP_MUL, S21, S02, A_T2, 1'b0);
            7'd24: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd25: u = mk(OP_MUL, A_T1, A_R, M01, 1'b1);
            // m02
            7'd26: u = mk(OP_MUL, S01, S12, A_T1, 1'b0);
            7'd27: u = mk(OP_MUL, S11, S02, A_T2, 1'b0);
            7'd28: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd29: u = mk(OP_MUL, A_T1, A_R, M02, 1'b0);
            // m10
            7'd30: u = mk(OP_MUL, S10, S22, A_T1, 1'b0);
            7'd31: u = mk(OP_MUL, S20, S12, A_T2, 1'b0);
            7'd32: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd33: u = mk(OP_MUL, A_T1, A_R, M10, 1'b1);
            // m11
            7'd34: u = mk(OP_MUL, S00, S22, A_T1, 1'b0);
            7'd35: u = mk(OP_MUL, S20, S02, A_T2, 1'b0);
            7'd36: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd37: u = mk(OP_MUL, A_T1, A_R, M11, 1'b0);
            // m12
            7'd38: u = mk(OP_MUL, S00, S12, A_T1, 1'b0);
            7'd39: u = mk(OP_MUL, S10, S02, A_T2, 1'b0);
            7'd40: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd41: u = mk(OP_MUL, A_T1, A_R, M12, 1'b1);
            // m20
            7'd42: u = mk(OP_MUL, S10, S21, A_T1, 1'b0);
            7'd43: u = mk(OP_MUL, S20, S11, A_T2, 1'b0);
            7'd44: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd45: u = mk(OP_MUL, A_T1, A_R, M20, 1'b0);
            // m21
            7'd46: u = mk(OP_MUL, S00, S21, A_T1, 1'b0);
            7'd47: u = mk(OP_MUL, S20, S01, A_T2, 1'b0);
            7'd48: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd49: u = mk(OP_MUL, A_T1, A_R, M21, 1'b1);
            // m22
            7'd50: u = mk(OP_MUL, S00, S11, A_T1, 1'b0);
            7'd51: u = mk(OP_MUL, S10, S01, A_T2, 1'b0);
            7'd52: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd53: u = mk(OP_MUL, A_T1, A_R, M22, 1'b0);
            // translation row 0
            7'd54: u = mk(OP_MUL, M00, S03, A_T1, 1'b1);
            7'd55: u = mk(OP_MUL, M01, S13, A_T2, 1'b0);
            7'd56: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd57: u = mk(OP_MUL, M02, S23, A_T2, 1'b0);
            7'd58: u = mk(OP_SUB, A_T1, A_T2, M03, 1'b0);
            // translation row 1
            7'd59: u = mk(OP_MUL, M10, S03, A_T1, 1'b1);
            7'd60: u = mk(OP_MUL, M11, S13, A_T2, 1'b0);
            7'd61: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd62: u = mk(OP_MUL, M12, S23, A_T2, 1'b0);
            7'd63: u = mk(OP_SUB, A_T1, A_T2, M13, 1'b0);
            // translation row 2
            7'd64: u = mk(OP_MUL, M20, S03, A_T1, 1'b1);
            7'd65: u = mk(OP_MUL, M21, S13, A_T2, 1'b0);
            7'd66: u = mk(OP_SUB, A_T1, A_T2, A_T1, 1'b0);
            7'd67: u = mk(OP_MUL, M22, S23, A_T2, 1'b0);
            7'd68: u = mk(OP_SUB, A_T1, A_T2, M23, 1'b0);
            default: u = mk(OP_ADD, A_T1, A_T1, A_T1, 1'b0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ami_stream_if.sv
`default_nettype none

// element input channel
interface ami_in_if;
    logic                       valid;
    logic                       ready;
    logic [ami_pkg::WORD_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

// inverse result channel
interface ami_out_if;
    logic                       valid;
    logic                       ready;
    logic [ami_pkg::WORD_W-1:0] value;
    logic                       last_element;
    logic                       singular;

    modport source (output valid, output value, output last_element, output singular,
                    input ready);
    modport sink   (input valid, input value, input last_element, input singular,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/affine_matrix_inverse.sv
`default_nettype none

// the twelve elements are loaded first, then the shared float work runs before the first result
// (69 operations in turn through one iterative float unit, the divide the longest of them;
// normalize shifts after cancellation or subnormals take longer); a singular matrix ends at the determinant
// one matrix at a time, input not ready meanwhile; each result is read in ST_ORD, then offered in ST_OVAL
// reset clears the sequencer, load count and float unit control; scratch memory is not reset
module affine_matrix_inverse (
    input  wire        clk,
    input  wire        rst_n,
    ami_in_if.sink     in_chan,
    ami_out_if.source  out_chan
);
    import ami_pkg::*;

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_READ = 6'b000010,
        ST_EXEC = 6'b000100,
        ST_WAIT = 6'b001000,
        ST_ORD  = 6'b010000,
        ST_OVAL = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [3:0]        oidx_reg, oidx_next;
    logic              sing_reg, sing_next;
    logic [WORD_W-1:0] rda_reg, rdb_reg;
    logic [WORD_W-1:0] mem [0:(1 << ADDR_W) - 1];

    uop_t              uop;
    logic              we, rd_en;
    logic [ADDR_W-1:0] wa, ra, rb;
    logic [WORD_W-1:0] wd;
    fpu_req_t          freq;
    fpu_rsp_t          frsp;
    logic              in_fire, out_fire;

    assign uop      = ucode(pc_reg);
    assign in_fire  = in_chan.valid && in_chan.ready;
    assign out_fire = out_chan.valid && out_chan.ready;

    ami_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (freq),
        .rsp   (frsp)
    );

    // operand fetch and float unit request
    always_comb
    begin
        ra         = (state_reg == ST_ORD) ? (A_M + {1'b0, oidx_reg}) : uop.a;
        rb         = uop.b;
        rd_en      = (state_reg == ST_READ) || (state_reg == ST_ORD);
        freq.start = (state_reg == ST_EXEC);
        freq.op    = uop.op;
        freq.a     = (uop.a == A_ONE) ? F_ONE : (rda_reg ^ {uop.neg, {(WORD_W-1){1'b0}}});
        freq.b     = rdb_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pc_next    = pc_reg;
        oidx_next  = oidx_reg;
        sing_next  = sing_reg;
        we         = 1'b0;
        wa         = {1'b0, cnt_reg};
        wd         = in_chan.element;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    we = 1'b1;
                    if (cnt_reg == 4'(N_ELEMS - 1))
                    begin
                        cnt_next   = 4'd0;
                        pc_next    = {PC_W{1'b0}};
                        state_next = ST_READ;
                    end
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_READ:
                state_next = ST_EXEC;
            ST_EXEC:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (frsp.done)
                begin
                    we = 1'b1;
                    wa = uop.d;
                    wd = frsp.result;
                    priority if ((pc_reg == PC_DET) && (frsp.result[WORD_W-2:0] == '0))
                    begin
                        sing_next  = 1'b1;
                        state_next = ST_OVAL;
                    end
                    else if (pc_reg == PC_LAST)
                    begin
                        oidx_next  = 4'd0;
                        state_next = ST_ORD;
                    end
                    else
                    begin
                        pc_next    = pc_reg + 7'd1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_ORD:
                state_next = ST_OVAL;
            ST_OVAL:
            begin
                if (out_fire)
                begin
                    if (sing_reg || (oidx_reg == 4'(N_ELEMS - 1)))
                    begin
                        sing_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        oidx_next  = oidx_reg + 4'd1;
                        state_next = ST_ORD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= 4'd0;
            pc_reg    <= {PC_W{1'b0}};
            oidx_reg  <= 4'd0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            oidx_reg  <= oidx_next;
            sing_reg  <= sing_next;
        end
    end

    // scratch memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
        begin
            rda_reg <= mem[ra];
            rdb_reg <= mem[rb];
        end
    end

    // channel ports
    assign in_chan.ready         = (state_reg == ST_LOAD);
    assign out_chan.valid        = (state_reg == ST_OVAL);
    assign out_chan.value        = sing_reg ? {WORD_W{1'b0}} : rda_reg;
    assign out_chan.last_element = sing_reg || (oidx_reg == 4'(N_ELEMS - 1));
    assign out_chan.singular     = sing_reg;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_chan.ready && out_chan.valid))
        else $error("input and output both active");

    a_sing_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_chan.valid && out_chan.singular) |-> out_chan.last_element)
        else $error("singular transaction not marked last");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        frsp.done |-> (state_reg == ST_WAIT))
        else $error("float result outside wait state");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        freq.start |-> !frsp.done)
        else $error("float unit busy at start");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < 4'(N_ELEMS))
        else $error("load count out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/ami_fpu.sv
`default_nettype none

module ami_fpu (
    input  wire                clk,
    input  wire                rst_n,
    input  ami_pkg::fpu_req_t  req,
    output ami_pkg::fpu_rsp_t  rsp
);
    import ami_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL    = 8'b0000_0010,
        S_ALIGN  = 8'b0000_0100,
        S_PRE    = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_NORM   = 8'b0010_0000,
        S_DENORM = 8'b0100_0000,
        S_ROUND  = 8'b1000_0000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic               done_reg, done_next;
    logic [WORD_W-1:0]  res_reg, res_next;
    logic               sign_reg, sign_next;
    logic               esub_reg, esub_next;
    logic signed [11:0] ea_reg, ea_next;
    logic signed [11:0] eb_reg, eb_next;
    logic signed [11:0] ex_reg, ex_next;
    logic [23:0]        ma_reg, ma_next;
    logic [23:0]        mb_reg, mb_next;
    logic [51:0]        n_reg, n_next;
    logic               st_reg, st_next;
    logic [25:0]        rem_reg, rem_next;
    logic [26:0]        q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;

    // operand decode
    logic [WORD_W-1:0]  opa, opb, opb_eff;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic               sx, swap;
    logic [23:0]        a_man, b_man;
    logic signed [11:0] a_exp, b_exp;

    // datapath temporaries
    logic [47:0]        prod;
    logic signed [11:0] dexp;
    logic [51:0]        afull, bfull, bsh, lost, nsum;
    logic               stb;
    logic               ge;
    logic [25:0]        rem_sel;
    logic [25:0]        rem_nx;
    logic [26:0]        q_nx;
    logic signed [11:0] sh;
    logic [51:0]        dmask;
    logic               up;
    logic [24:0]        mant25;
    logic [23:0]        m24;
    logic signed [11:0] exf;

    always_comb
    begin
        opa     = req.a;
        opb     = req.b;
        opb_eff = (req.op == OP_SUB) ? {~req.b[31], req.b[30:0]} : req.b;
        a_nan   = (opa[30:23] == 8'hFF) && (opa[22:0] != 23'd0);
        b_nan   = (opb[30:23] == 8'hFF) && (opb[22:0] != 23'd0);
        a_inf   = (opa[30:23] == 8'hFF) && (opa[22:0] == 23'd0);
        b_inf   = (opb[30:23] == 8'hFF) && (opb[22:0] == 23'd0);
        a_zero  = (opa[30:0] == 31'd0);
        b_zero  = (opb[30:0] == 31'd0);
        sx      = opa[31] ^ opb[31];
        swap    = (opa[30:0] < opb[30:0]);
        a_man   = {opa[30:23] != 8'h00, opa[22:0]};
        b_man   = {opb[30:23] != 8'h00, opb[22:0]};
        a_exp   = (opa[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, opa[30:23]});
        b_exp   = (opb[30:23] == 8'h00) ? 12'sd1 : $signed({4'b0, opb[30:23]});
    end

    // datapath shared by the states
    always_comb
    begin
        prod  = ma_reg * mb_reg;
        dexp  = ea_reg - eb_reg;
        afull = {1'b0, ma_reg, 27'd0};
        bfull = {1'b0, mb_reg, 27'd0};
        if (dexp > 12'sd51)
        begin
            bsh  = 52'd0;
            lost = 52'd0;
            stb  = |mb_reg;
        end
        else
        begin
            bsh  = bfull >> dexp[5:0];
            lost = bfull & ~({52{1'b1}} << dexp[5:0]);
            stb  = |lost;
        end
        nsum = esub_reg ? (afull - bsh - {51'd0, stb}) : (afull + bsh);

        ge      = (rem_reg >= {2'b00, mb_reg});
        rem_sel = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
        rem_nx  = {rem_sel[24:0], 1'b0};
        q_nx    = {q_reg[25:0], ge};

        sh    = 12'sd1 - ex_reg;
        dmask = ~({52{1'b1}} << sh[5:0]);

        up     = n_reg[27] & ((|n_reg[26:0]) | st_reg | n_reg[28]);
        mant25 = {1'b0, n_reg[51:28]} + {24'd0, up};
        m24    = mant25[24] ? mant25[24:1] : mant25[23:0];
        exf    = mant25[24] ? (ex_reg + 12'sd1) : ex_reg;
    end

    // operation sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        sign_next  = sign_reg;
        esub_next  = esub_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        ex_next    = ex_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        n_next     = n_reg;
        st_next    = st_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    ma_next = a_man;
                    mb_next = b_man;
                    ea_next = a_exp;
                    eb_next = b_exp;
                    if (a_nan)
                    begin
                        res_next  = opa | F_QBIT;
                        done_next = 1'b1;
                    end
                    else if (b_nan)
                    begin
                        res_next  = opb | F_QBIT;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        unique case (req.op)
                            OP_MUL:
                            begin
                                done_next = 1'b1;
                                sign_next = sx;
                                priority if ((a_inf && b_zero) || (a_zero && b_inf))
                                    res_next = F_DEFNAN;
                                else if (a_inf || b_inf)
                                    res_next = {sx, 8'hFF, 23'd0};
                                else if (a_zero || b_zero)
                                    res_next = {sx, 31'd0};
                                else
                                begin
                                    done_next  = 1'b0;
                                    state_next = S_MUL;
                                end
                            end
                            OP_DIV:
                            begin
                                done_next = 1'b1;
                                sign_next = sx;
                                priority if ((a_inf && b_inf) || (a_zero && b_zero))
                                    res_next = F_DEFNAN;
                                else if (a_inf || b_zero)
                                    res_next = {sx, 8'hFF, 23'd0};
                                else if (a_zero || b_inf)
                                    res_next = {sx, 31'd0};
                                else
                                begin
                                    done_next  = 1'b0;
                                    state_next = S_PRE;
                                end
                            end
                            default:
                            begin
                                done_next = 1'b1;
                                esub_next = opa[31] ^ opb_eff[31];
                                priority if (a_inf && b_inf && (opa[31] != opb_eff[31]))
                                    res_next = F_DEFNAN;
                                else if (a_inf)
                                    res_next = opa;
                                else if (b_inf)
                                    res_next = opb_eff;
                                else if (a_zero && b_zero)
                                    res_next = {opa[31] & opb_eff[31], 31'd0};
                                else if (a_zero)
                                    res_next = opb_eff;
                                else if (b_zero)
                                    res_next = opa;
                                else
                                begin
                                    done_next  = 1'b0;
                                    state_next = S_ALIGN;
                                    // larger magnitude goes to the a side
                                    if (swap)
                                    begin
                                        sign_next = opb_eff[31];
                                        ma_next   = b_man;
                                        mb_next   = a_man;
                                        ea_next   = b_exp;
                                        eb_next   = a_exp;
                                    end
                                    else
                                        sign_next = opa[31];
                                end
                            end
                        endcase
                    end
                end
            end
            S_MUL:
            begin
                n_next     = {prod, 4'd0};
                st_next    = 1'b0;
                ex_next    = ea_reg + eb_reg - 12'sd126;
                state_next = S_NORM;
            end
            S_ALIGN:
            begin
                n_next  = nsum;
                st_next = stb;
                ex_next = ea_reg + 12'sd1;
                if ((nsum == 52'd0) && !stb)
                begin
                    res_next   = {WORD_W{1'b0}};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_NORM;
            end
            S_PRE:
            begin
                // bring both mantissas to a leading one
                priority if (!ma_reg[23])
                begin
                    ma_next = {ma_reg[22:0], 1'b0};
                    ea_next = ea_reg - 12'sd1;
                end
                else if (!mb_reg[23])
                begin
                    mb_next = {mb_reg[22:0], 1'b0};
                    eb_next = eb_reg - 12'sd1;
                end
                else
                begin
                    rem_next   = {2'b00, ma_reg};
                    q_next     = 27'd0;
                    cnt_next   = 5'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // one restoring quotient bit per cycle
                rem_next = rem_nx;
                q_next   = q_nx;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd26)
                begin
                    n_next     = {q_nx, 25'd0};
                    st_next    = |rem_nx;
                    ex_next    = ea_reg - eb_reg + 12'sd127;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (!n_reg[51])
                begin
                    n_next  = {n_reg[50:0], 1'b0};
                    ex_next = ex_reg - 12'sd1;
                end
                else
                    state_next = S_DENORM;
            end
            S_DENORM:
            begin
                if (ex_reg < 12'sd1)
                begin
                    ex_next = 12'sd1;
                    if (sh > 12'sd51)
                    begin
                        n_next  = 52'd0;
                        st_next = st_reg | (|n_reg);
                    end
                    else
                    begin
                        n_next  = n_reg >> sh[5:0];
                        st_next = st_reg | (|(n_reg & dmask));
                    end
                end
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (exf > 12'sd254)
                    res_next = {sign_reg, 8'hFF, 23'd0};
                else
                    res_next = {sign_reg, (m24[23] ? exf[7:0] : 8'h00), m24[22:0]};
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        sign_reg <= sign_next;
        esub_reg <= esub_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ex_reg   <= ex_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        n_reg    <= n_next;
        st_reg   <= st_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

`default_nettype wire

FILE: tb/sv/ami_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts the inverse and compares each result transaction
module ami_checker (
    input  wire  clk,
    input  wire  rst_n,
    ami_in_if    in_mon,
    ami_out_if   out_mon,
    output int   errors,
    output int   pending
);

    typedef struct {
        logic [31:0] value;
        logic        last_element;
        logic        singular;
    } inv_item_t;

    inv_item_t   inverse_q[$];
    logic [31:0] elem_store[12];
    int          elem_count;

    // single precision helpers, round to nearest even
    function automatic bit is_nan(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit is_inf(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction

    function automatic bit is_zero(logic [31:0] x);
        return x[30:0] == 0;
    endfunction

    function automatic logic [31:0] nan_pick(logic [31:0] a, logic [31:0] b);
        if (is_nan(a))
            return a | ami_pkg::F_QBIT;
        return b | ami_pkg::F_QBIT;
    endfunction

    function automatic logic [63:0] shr_sticky(logic [63:0] v, int sh);
        if (sh > 63)
            return {63'd0, v != 0};
        return (v >> sh) | {63'd0, (v & ((64'd1 << sh) - 1)) != 0};
    endfunction

    function automatic void unpack_f(input logic [31:0] x, output logic [63:0] sig,
                                     output int ex);
        if (x[30:23] == 0)
        begin
            sig = {41'd0, x[22:0]};
            ex  = 1;
        end
        else
        begin
            sig = {40'd0, 1'b1, x[22:0]};
            ex  = int'(x[30:23]);
        end
    endfunction

    // value is m * 2^ex; m carries a sticky bit in its lsb
    function automatic logic [31:0] round_pack(bit sgn, int ex, logic [63:0] m);
        int          e;
        logic [63:0] enc;
        bit          up;
        if (m == 0)
            return {sgn, 31'd0};
        while (!m[63])
        begin
            m  = m << 1;
            ex = ex - 1;
        end
        e = ex + 190;
        if (e < 1)
        begin
            m = shr_sticky(m, 1 - e);
            e = 1;
        end
        up  = m[39] && (m[38:0] != 0 || m[40]);
        enc = (64'(e - 1) << 23) + {40'd0, m[63:40]} + {63'd0, up};
        if (enc >= 64'h7F80_0000)
            return {sgn, 8'hFF, 23'd0};
        return {sgn, enc[30:0]};
    endfunction

    function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
        bit          s;
        logic [63:0] sa, sb;
        int          ea, eb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b))
            return nan_pick(a, b);
        if (is_inf(a) || is_inf(b))
        begin
            if (is_zero(a) || is_zero(b))
                return ami_pkg::F_DEFNAN;
            return {s, 8'hFF, 23'd0};
        end
        unpack_f(a, sa, ea);
        unpack_f(b, sb, eb);
        return round_pack(s, ea + eb - 300, sa * sb);
    endfunction

    function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b, bit negb);
        logic [31:0] bb;
        logic [63:0] sa, sb, m;
        int          ea, eb, ex;
        bit          s;
        if (is_nan(a) || is_nan(b))
            return nan_pick(a, b);
        bb = b ^ {negb, 31'd0};
        if (is_inf(a) && is_inf(bb) && a[31] != bb[31])
            return ami_pkg::F_DEFNAN;
        if (is_inf(a))
            return a;
        if (is_inf(bb))
            return bb;
        if (is_zero(a) && is_zero(bb))
            return {a[31] & bb[31], 31'd0};
        if (is_zero(a))
            return bb;
        if (is_zero(bb))
            return a;
        unpack_f(a, sa, ea);
        unpack_f(bb, sb, eb);
        sa = sa << 39;
        sb = sb << 39;
        if (ea >= eb)
        begin
            sb = shr_sticky(sb, ea - eb);
            ex = ea - 189;
        end
        else
        begin
            sa = shr_sticky(sa, eb - ea);
            ex = eb - 189;
        end
        if (a[31] == bb[31])
        begin
            m = sa + sb;
            s = a[31];
        end
        else if (sa >= sb)
        begin
            m = sa - sb;
            s = a[31];
        end
        else
        begin
            m = sb - sa;
            s = bb[31];
        end
        if (m == 0)
            return 32'd0;
        return round_pack(s, ex, m);
    endfunction

    function automatic logic [31:0] fdiv(logic [31:0] a, logic [31:0] b);
        bit          s;
        logic [63:0] sa, sb, q;
        int          ea, eb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b))
            return nan_pick(a, b);
        if ((is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b)))
            return ami_pkg::F_DEFNAN;
        if (is_inf(a) || is_zero(b))
            return {s, 8'hFF, 23'd0};
        if (is_inf(b) || is_zero(a))
            return {s, 31'd0};
        unpack_f(a, sa, ea);
        unpack_f(b, sb, eb);
        while (!sa[23])
        begin
            sa = sa << 1;
            ea = ea - 1;
        end
        while (!sb[23])
        begin
            sb = sb << 1;
            eb = eb - 1;
        end
        q = (sa << 40) / sb;
        q = q | {63'd0, ((sa << 40) % sb) != 0};
        return round_pack(s, ea - eb - 40, q);
    endfunction

    // (a*b - c*d) * r, negated before the scale when neg is set
    function automatic logic [31:0] cofactor(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                             logic [31:0] d, logic [31:0] r, bit neg);
        logic [31:0] t;
        t = fadd(fmul(a, b), fmul(c, d), 1'b1);
        if (neg)
            t[31] = ~t[31];
        return fmul(t, r);
    endfunction

    // inverse of the stored matrix, queued as expected result transactions
    function automatic void predict_inverse();
        logic [31:0] s[12];
        logic [31:0] m[12];
        logic [31:0] det, r, t;
        inv_item_t   it;
        s   = elem_store;
        det = fmul(fmul(s[0], s[5]), s[10]);
        det = fadd(det, fmul(fmul(s[1], s[6]), s[8]), 1'b0);
        det = fadd(det, fmul(fmul(s[2], s[4]), s[9]), 1'b0);
        det = fadd(det, fmul(fmul(s[8], s[5]), s[2]), 1'b1);
        det = fadd(det, fmul(fmul(s[4], s[1]), s[10]), 1'b1);
        det = fadd(det, fmul(fmul(s[0], s[9]), s[6]), 1'b1);
        if (is_zero(det))
        begin
            it.value        = 32'd0;
            it.last_element = 1'b1;
            it.singular     = 1'b1;
            inverse_q.push_back(it);
            return;
        end
        r     = fdiv(ami_pkg::F_ONE, det);
        m[0]  = cofactor(s[5], s[10], s[9], s[6], r, 1'b0);
        m[1]  = cofactor(s[1], s[10], s[9], s[2], r, 1'b1);
        m[2]  = cofactor(s[1], s[6], s[5], s[2], r, 1'b0);
        m[4]  = cofactor(s[4], s[10], s[8], s[6], r, 1'b1);
        m[5]  = cofactor(s[0], s[10], s[8], s[2], r, 1'b0);
        m[6]  = cofactor(s[0], s[6], s[4], s[2], r, 1'b1);
        m[8]  = cofactor(s[4], s[9], s[8], s[5], r, 1'b0);
        m[9]  = cofactor(s[0], s[9], s[8], s[1], r, 1'b1);
        m[10] = cofactor(s[0], s[5], s[4], s[1], r, 1'b0);
        for (int i = 0; i < 3; i++)
        begin
            t = fmul(m[i*4] ^ 32'h8000_0000, s[3]);
            t = fadd(t, fmul(m[i*4+1], s[7]), 1'b1);
            t = fadd(t, fmul(m[i*4+2], s[11]), 1'b1);
            m[i*4+3] = t;
        end
        for (int k = 0; k < 12; k++)
        begin
            it.value        = m[k];
            it.last_element = (k == 11);
            it.singular     = 1'b0;
            inverse_q.push_back(it);
        end
    endfunction

    assign pending = inverse_q.size();

    // compare result transactions, then take in element transactions
    always @(posedge clk or negedge rst_n)
    begin
        inv_item_t exp_item;
        if (!rst_n)
        begin
            errors     <= 0;
            elem_count <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h last=%b singular=%b", $time,
                             out_mon.value, out_mon.last_element, out_mon.singular);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_item = inverse_q.pop_front();
                    if (out_mon.value !== exp_item.value
                        || out_mon.last_element !== exp_item.last_element
                        || out_mon.singular !== exp_item.singular)
                    begin
                        $display("%0t: mismatch expected value=%h last=%b singular=%b, actual value=%h last=%b singular=%b",
                                 $time, exp_item.value, exp_item.last_element,
                                 exp_item.singular, out_mon.value, out_mon.last_element,
                                 out_mon.singular);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                elem_store[elem_count] = in_mon.element;
                if (elem_count == 11)
                begin
                    predict_inverse();
                    elem_count <= 0;
                end
                else
                    elem_count <= elem_count + 1;
            end
        end
    end

endmodule

FILE: tb/sv/affine_matrix_inverse_tb.sv
`timescale 1ns / 1ps

module affine_matrix_inverse_tb;

    localparam int RAND_MATRICES = 20;
    localparam int STALL_LIMIT   = 6000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    bit   idle_on;
    bit   hold_req;

    ami_in_if  in_chan ();
    ami_out_if out_chan ();

    affine_matrix_inverse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    ami_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_mon  (in_chan),
        .out_mon (out_chan),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // send one element transaction, with an optional gap in front
    task automatic send_element(logic [31:0] w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_chan.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_chan.valid   = 1'b1;
        in_chan.element = w;
        while (!in_chan.ready)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] special_value();
        logic [31:0] pool[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                                  32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                                  32'h3F80_0000};
        return pool[$urandom_range(0, 9)];
    endfunction

    // moderate magnitudes, now and then a subnormal
    function automatic logic [31:0] tame_value();
        if ($urandom_range(0, 19) == 0)
            return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
        return {$urandom_range(0, 1) == 1, 8'($urandom_range(118, 136)), 23'($urandom)};
    endfunction

    task automatic send_matrix(int kind);
        logic [31:0] w;
        for (int k = 0; k < 12; k++)
        begin
            case (kind)
                0, 1:    w = tame_value();
                2:       w = (k % 4 == 0) ? $urandom_range(0, 1) << 31 : tame_value();
                3:       w = $urandom;
                default: w = ($urandom_range(0, 2) == 0) ? special_value() : tame_value();
            endcase
            send_element(w);
        end
    endtask

    // result side: random stalls and one long hold-off on request
    initial
    begin
        out_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_chan.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_chan.ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_chan.ready = 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, quiet);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [31:0] ident[12] = '{32'h3F80_0000, 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                                   32'h0000_0000, 32'h3F80_0000, 32'h0000_0000, 32'h7F7F_FFFF,
                                   32'h8000_0000, 32'h0000_0000, 32'h3F80_0000, 32'h8000_0001};
        int drain;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        in_chan.valid   = 1'b0;
        in_chan.element = '0;
        rst_n           = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity with extreme translation, then an all-zero singular matrix
        foreach (ident[k])
            send_element(ident[k]);
        for (int k = 0; k < 12; k++)
            send_element((k % 2) ? 32'h8000_0000 : 32'h0000_0000);

        for (int n = 0; n < RAND_MATRICES; n++)
        begin
            if (n == 5)
                hold_req = 1'b1;
            if (n == RAND_MATRICES - 4)
                idle_on = 1'b0;
            send_matrix($urandom_range(0, 4));
        end
        in_chan.valid = 1'b0;

        drain = 0;
        while (pending != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain = drain + 1;
        end
        repeat (200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/ami_pkg.sv
rtl/ami_stream_if.sv
rtl/ami_fpu.sv
rtl/affine_matrix_inverse.sv
tb/sv/ami_checker.sv
tb/sv/affine_matrix_inverse_tb.sv
